/* sv/glcm_pkg.sv */
// Shared types, register indexes and constants for the co-occurrence matrix block.
package glcm_pkg;

  localparam int unsigned MAX_BINS_DEF   = 64;
  localparam int unsigned MAX_DIM_DEF    = 4096;
  localparam int unsigned PIXEL_BITS_DEF = 8;
  localparam int unsigned COUNT_BITS_DEF = 24;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned LEVELS_W   = 9;
  localparam int unsigned BINS_CFG_W = 7;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned READ_W     = 6;

  localparam int unsigned OUT_FIFO_DEPTH = 8;

  localparam logic [LEVELS_W-1:0]   LEVELS_RST  = 9'd256;
  localparam logic [BINS_CFG_W-1:0] BINS_RST    = 7'd8;
  localparam logic [COORD_W-1:0]    PATCH_XY_RST = 12'd0;
  localparam logic [SIZE_W-1:0]     PATCH_WH_RST = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVELS  = 3'd0,
    CFG_BINS    = 3'd1,
    CFG_PATCH_X = 3'd2,
    CFG_PATCH_Y = 3'd3,
    CFG_PATCH_W = 3'd4,
    CFG_PATCH_H = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    OP_ACC  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
  } patch_t;

  // vld: memory operation present; rd: read and clear; hit: read address inside the store
  typedef struct packed {
    logic vld;
    logic rd;
    logic hit;
  } mem_ctl_t;

endpackage

/* sv/glcm_accumulator.sv */
// Top level: gray-level co-occurrence matrix accumulator with result queue.
// Throughput: one beat per cycle, accumulate or read, up to OUT_FIFO_DEPTH reads outstanding.
// Read beats reach the result queue via quantiser and store stages; accumulate beats do not.
// Store update is read-modify-write on one memory port pair, same-entry hits forwarded.
// A levels or bins write holds input off while two serial divisions run.
// Reset: synchronous; clearing pass over MAX_BINS*MAX_BINS entries (4096) holds input off.
module glcm_accumulator #(
  parameter int unsigned MAX_BINS   = glcm_pkg::MAX_BINS_DEF,
  parameter int unsigned MAX_DIM    = glcm_pkg::MAX_DIM_DEF,
  parameter int unsigned PIXEL_BITS = glcm_pkg::PIXEL_BITS_DEF,
  parameter int unsigned COUNT_BITS = glcm_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [glcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [glcm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_op,
  input  logic [PIXEL_BITS-1:0]            in_ref_pixel,
  input  logic [PIXEL_BITS-1:0]            in_nbr_pixel,
  input  logic                             in_nbr_inside,
  input  logic [glcm_pkg::COORD_W-1:0]     in_pixel_row,
  input  logic [glcm_pkg::COORD_W-1:0]     in_pixel_col,
  input  logic [glcm_pkg::READ_W-1:0]      in_read_row,
  input  logic [glcm_pkg::READ_W-1:0]      in_read_col,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [COUNT_BITS-1:0]            out_count,
  output logic [glcm_pkg::READ_W-1:0]      out_entry_row,
  output logic [glcm_pkg::READ_W-1:0]      out_entry_col
);

  localparam int unsigned BIN_W  = $clog2(MAX_BINS);
  localparam int unsigned ADDR_W = $clog2(MAX_BINS * MAX_BINS);
  localparam int unsigned RCP_W  = PIXEL_BITS + glcm_pkg::LEVELS_W + 1;
  localparam int unsigned DEPTH  = glcm_pkg::OUT_FIFO_DEPTH;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned RW     = glcm_pkg::READ_W;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [RW-1:0]         row;
    logic [RW-1:0]         col;
  } res_t;

  glcm_pkg::patch_t    patch;
  logic [BIN_W-1:0]    bins_m1;
  logic [RCP_W-1:0]    recip;
  logic                cfg_rdy;
  logic                in_fire;
  glcm_pkg::mem_ctl_t  req;
  logic [ADDR_W-1:0]   req_addr;
  logic [RW-1:0]       req_row;
  logic [RW-1:0]       req_col;
  logic                mem_res_vld;
  logic [COUNT_BITS-1:0] mem_res_count;
  logic [RW-1:0]       mem_res_row;
  logic [RW-1:0]       mem_res_col;
  logic                clr_done;

  res_t                fifo_mem [DEPTH];
  logic [PTR_W-1:0]    wptr_r;
  logic [PTR_W-1:0]    rptr_r;
  logic [CNT_W-1:0]    fifo_cnt_r;
  logic [CNT_W-1:0]    used_r;
  logic                pop;
  logic                rd_beat;
  res_t                head;

  glcm_cfg #(
    .MAX_BINS   (MAX_BINS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .patch     (patch),
    .bins_m1   (bins_m1),
    .recip     (recip),
    .ready     (cfg_rdy)
  );

  glcm_quant #(
    .MAX_BINS   (MAX_BINS),
    .MAX_DIM    (MAX_DIM),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_quant (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .in_op         (in_op),
    .in_ref_pixel  (in_ref_pixel),
    .in_nbr_pixel  (in_nbr_pixel),
    .in_nbr_inside (in_nbr_inside),
    .in_pixel_row  (in_pixel_row),
    .in_pixel_col  (in_pixel_col),
    .in_read_row   (in_read_row),
    .in_read_col   (in_read_col),
    .patch         (patch),
    .bins_m1       (bins_m1),
    .recip         (recip),
    .req           (req),
    .req_addr      (req_addr),
    .req_row       (req_row),
    .req_col       (req_col)
  );

  glcm_mem #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .req_addr  (req_addr),
    .req_row   (req_row),
    .req_col   (req_col),
    .res_vld   (mem_res_vld),
    .res_count (mem_res_count),
    .res_row   (mem_res_row),
    .res_col   (mem_res_col),
    .clr_done  (clr_done)
  );

  // used_r counts read beats in flight plus queued results
  assign in_ready = cfg_rdy && clr_done && (used_r < CNT_W'(DEPTH));
  assign in_fire  = in_valid && in_ready;
  assign rd_beat  = in_fire && (in_op == glcm_pkg::OP_READ);
  assign pop      = out_valid && out_ready;
  assign head     = fifo_mem[rptr_r];

  always_ff @(posedge clk) begin
    if (mem_res_vld) begin
      fifo_mem[wptr_r] <= '{count: mem_res_count, row: mem_res_row, col: mem_res_col};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r     <= '0;
      rptr_r     <= '0;
      fifo_cnt_r <= '0;
      used_r     <= '0;
    end else begin
      if (mem_res_vld) begin
        wptr_r <= wptr_r + PTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + PTR_W'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + CNT_W'(mem_res_vld) - CNT_W'(pop);
      used_r     <= used_r + CNT_W'(rd_beat) - CNT_W'(pop);
    end
  end

  assign out_valid     = (fifo_cnt_r != '0);
  assign out_count     = head.count;
  assign out_entry_row = head.row;
  assign out_entry_col = head.col;

  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    mem_res_vld |-> (fifo_cnt_r != CNT_W'(DEPTH)))
    else $error("result queue overflow");

  a_credit_cover: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= used_r)
    else $error("queued results exceed outstanding reads");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_done |-> !mem_res_vld)
    else $error("result produced during clearing pass");

endmodule

/* sv/glcm_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
module glcm_div #(
  parameter int unsigned DVD_W = 18,
  parameter int unsigned DVS_W = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t          state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic             done_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             take;

  always_comb begin
    trial = {rem_r, quo_r[DVD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    take  = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            quo_r   <= dividend;
            rem_r   <= '0;
            dvs_r   <= divisor;
            cnt_r   <= CNT_W'(DVD_W);
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          quo_r <= {quo_r[DVD_W-2:0], take};
          rem_r <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_r <= D_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* sv/glcm_cfg.sv */
// Configuration registers and bin-width setup: bin width and its reciprocal.
module glcm_cfg #(
  parameter int unsigned MAX_BINS   = glcm_pkg::MAX_BINS_DEF,
  parameter int unsigned PIXEL_BITS = glcm_pkg::PIXEL_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [glcm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [glcm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output glcm_pkg::patch_t                     patch,
  output logic [$clog2(MAX_BINS)-1:0]          bins_m1,
  output logic [PIXEL_BITS+glcm_pkg::LEVELS_W:0] recip,
  output logic                                 ready
);

  localparam int unsigned LW    = glcm_pkg::LEVELS_W;
  localparam int unsigned K     = PIXEL_BITS + LW;
  localparam int unsigned DVD_W = K + 1;
  localparam int unsigned BIN_W = $clog2(MAX_BINS);

  typedef enum logic [1:0] {S_IDLE, S_WIDTH, S_RECIP} sstate_t;

  sstate_t                           state_r;
  logic                              dirty_r;
  logic                              start_r;
  logic [DVD_W-1:0]                  dvd_r;
  logic [LW-1:0]                     dvs_r;
  logic [DVD_W-1:0]                  recip_r;
  logic [LW-1:0]                     levels_r;
  logic [glcm_pkg::BINS_CFG_W-1:0]   bins_cfg_r;
  glcm_pkg::patch_t                  patch_r;
  logic [LW-1:0]                     bins_eff;
  logic [LW-1:0]                     wq;
  logic [LW-1:0]                     wdt;
  logic [DVD_W-1:0]                  rnd;
  logic                              div_done;
  logic [DVD_W-1:0]                  div_q;

  always_comb begin
    priority if (bins_cfg_r == '0) begin
      bins_eff = LW'(1);
    end else if (32'(bins_cfg_r) > MAX_BINS) begin
      bins_eff = LW'(MAX_BINS);
    end else begin
      bins_eff = LW'(bins_cfg_r);
    end
    wq  = div_q[LW-1:0];
    wdt = (wq == '0) ? LW'(1) : wq;
    // dividend for ceil(2^K / width)
    rnd = (DVD_W'(1) << K) + DVD_W'(wdt) - DVD_W'(1);
  end

  glcm_div #(
    .DVD_W (DVD_W),
    .DVS_W (LW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (dvd_r),
    .divisor  (dvs_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      dirty_r    <= 1'b1;
      start_r    <= 1'b0;
      levels_r   <= glcm_pkg::LEVELS_RST;
      bins_cfg_r <= glcm_pkg::BINS_RST;
      patch_r.x  <= glcm_pkg::PATCH_XY_RST;
      patch_r.y  <= glcm_pkg::PATCH_XY_RST;
      patch_r.w  <= glcm_pkg::PATCH_WH_RST;
      patch_r.h  <= glcm_pkg::PATCH_WH_RST;
    end else begin
      start_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (dirty_r) begin
            dirty_r <= 1'b0;
            start_r <= 1'b1;
            dvd_r   <= DVD_W'(levels_r);
            dvs_r   <= bins_eff;
            state_r <= S_WIDTH;
          end
        end
        S_WIDTH: begin
          if (div_done) begin
            start_r <= 1'b1;
            dvd_r   <= rnd;
            dvs_r   <= wdt;
            state_r <= S_RECIP;
          end
        end
        S_RECIP: begin
          if (div_done) begin
            recip_r <= div_q;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (cfg_wr_en) begin
        unique case (cfg_index)
          glcm_pkg::CFG_LEVELS: begin
            levels_r <= cfg_wdata[LW-1:0];
            dirty_r  <= 1'b1;
          end
          glcm_pkg::CFG_BINS: begin
            bins_cfg_r <= cfg_wdata[glcm_pkg::BINS_CFG_W-1:0];
            dirty_r    <= 1'b1;
          end
          glcm_pkg::CFG_PATCH_X: patch_r.x <= cfg_wdata[glcm_pkg::COORD_W-1:0];
          glcm_pkg::CFG_PATCH_Y: patch_r.y <= cfg_wdata[glcm_pkg::COORD_W-1:0];
          glcm_pkg::CFG_PATCH_W: patch_r.w <= cfg_wdata[glcm_pkg::SIZE_W-1:0];
          glcm_pkg::CFG_PATCH_H: patch_r.h <= cfg_wdata[glcm_pkg::SIZE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign patch   = patch_r;
  assign bins_m1 = BIN_W'(bins_eff - LW'(1));
  assign recip   = recip_r;
  assign ready   = (state_r == S_IDLE) && !dirty_r;

endmodule

/* sv/glcm_quant.sv */
// Patch test, pixel quantiser and matrix address generation, pipelined.
module glcm_quant #(
  parameter int unsigned MAX_BINS   = glcm_pkg::MAX_BINS_DEF,
  parameter int unsigned MAX_DIM    = glcm_pkg::MAX_DIM_DEF,
  parameter int unsigned PIXEL_BITS = glcm_pkg::PIXEL_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_fire,
  input  logic                                    in_op,
  input  logic [PIXEL_BITS-1:0]                   in_ref_pixel,
  input  logic [PIXEL_BITS-1:0]                   in_nbr_pixel,
  input  logic                                    in_nbr_inside,
  input  logic [glcm_pkg::COORD_W-1:0]            in_pixel_row,
  input  logic [glcm_pkg::COORD_W-1:0]            in_pixel_col,
  input  logic [glcm_pkg::READ_W-1:0]             in_read_row,
  input  logic [glcm_pkg::READ_W-1:0]             in_read_col,
  input  glcm_pkg::patch_t                        patch,
  input  logic [$clog2(MAX_BINS)-1:0]             bins_m1,
  input  logic [PIXEL_BITS+glcm_pkg::LEVELS_W:0]  recip,
  output glcm_pkg::mem_ctl_t                      req,
  output logic [$clog2(MAX_BINS*MAX_BINS)-1:0]    req_addr,
  output logic [glcm_pkg::READ_W-1:0]             req_row,
  output logic [glcm_pkg::READ_W-1:0]             req_col
);

  localparam int unsigned K      = PIXEL_BITS + glcm_pkg::LEVELS_W;
  localparam int unsigned RCP_W  = K + 1;
  localparam int unsigned PW     = PIXEL_BITS + RCP_W;
  localparam int unsigned BIN_W  = $clog2(MAX_BINS);
  localparam int unsigned ADDR_W = $clog2(MAX_BINS * MAX_BINS);
  localparam int unsigned RW     = glcm_pkg::READ_W;

  function automatic logic [BIN_W-1:0] clamp_bin(input logic [PIXEL_BITS-1:0] q,
                                                 input logic [BIN_W-1:0] lim);
    logic [BIN_W-1:0] r;
    if (32'(q) > 32'(lim)) begin
      r = lim;
    end else begin
      r = BIN_W'(q);
    end
    return r;
  endfunction

  // stage 0
  logic                          vld0_r;
  logic                          op0_r;
  logic [PIXEL_BITS-1:0]         ref0_r;
  logic [PIXEL_BITS-1:0]         nbr0_r;
  logic                          inside0_r;
  logic [glcm_pkg::COORD_W-1:0]  row0_r;
  logic [glcm_pkg::COORD_W-1:0]  col0_r;
  logic [RW-1:0]                 rrow0_r;
  logic [RW-1:0]                 rcol0_r;
  // stage 1
  logic                          vld1_r;
  logic                          op1_r;
  logic                          take1_r;
  logic [PW-1:0]                 pref1_r;
  logic [PW-1:0]                 pnbr1_r;
  logic [RW-1:0]                 rrow1_r;
  logic [RW-1:0]                 rcol1_r;
  // request
  glcm_pkg::mem_ctl_t            req_r;
  logic [ADDR_W-1:0]             addr_r;
  logic [RW-1:0]                 row2_r;
  logic [RW-1:0]                 col2_r;

  logic                          row_ok;
  logic                          col_ok;
  logic [BIN_W-1:0]              ridx;
  logic [BIN_W-1:0]              cidx;
  logic                          rd_hit;
  logic [ADDR_W-1:0]             acc_addr;
  logic [ADDR_W-1:0]             rd_addr;

  always_comb begin
    row_ok = (32'(row0_r) < MAX_DIM) && (row0_r >= patch.y) &&
             (32'(row0_r) < 32'(patch.y) + 32'(patch.h));
    col_ok = (32'(col0_r) < MAX_DIM) && (col0_r >= patch.x) &&
             (32'(col0_r) < 32'(patch.x) + 32'(patch.w));
    ridx     = clamp_bin(pref1_r[K+PIXEL_BITS-1:K], bins_m1);
    cidx     = clamp_bin(pnbr1_r[K+PIXEL_BITS-1:K], bins_m1);
    acc_addr = ADDR_W'(32'(ridx) * MAX_BINS + 32'(cidx));
    rd_hit   = (32'(rrow1_r) < MAX_BINS) && (32'(rcol1_r) < MAX_BINS);
    rd_addr  = ADDR_W'(32'(rrow1_r) * MAX_BINS + 32'(rcol1_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r  <= 1'b0;
      vld1_r  <= 1'b0;
      req_r   <= '0;
    end else begin
      vld0_r    <= in_fire;
      vld1_r    <= vld0_r;
      req_r.vld <= vld1_r && (op1_r || take1_r);
      req_r.rd  <= op1_r;
      req_r.hit <= rd_hit;
    end
    if (in_fire) begin
      op0_r     <= in_op;
      ref0_r    <= in_ref_pixel;
      nbr0_r    <= in_nbr_pixel;
      inside0_r <= in_nbr_inside;
      row0_r    <= in_pixel_row;
      col0_r    <= in_pixel_col;
      rrow0_r   <= in_read_row;
      rcol0_r   <= in_read_col;
    end
    op1_r   <= op0_r;
    take1_r <= inside0_r && row_ok && col_ok;
    pref1_r <= PW'(ref0_r) * PW'(recip);
    pnbr1_r <= PW'(nbr0_r) * PW'(recip);
    rrow1_r <= rrow0_r;
    rcol1_r <= rcol0_r;
    addr_r  <= op1_r ? rd_addr : acc_addr;
    row2_r  <= rrow1_r;
    col2_r  <= rcol1_r;
  end

  assign req      = req_r;
  assign req_addr = addr_r;
  assign req_row  = row2_r;
  assign req_col  = col2_r;

endmodule

/* sv/glcm_mem.sv */
// Count store with read-modify-write, write forwarding and clearing pass.
module glcm_mem #(
  parameter int unsigned MAX_BINS   = glcm_pkg::MAX_BINS_DEF,
  parameter int unsigned COUNT_BITS = glcm_pkg::COUNT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  glcm_pkg::mem_ctl_t                    req,
  input  logic [$clog2(MAX_BINS*MAX_BINS)-1:0]  req_addr,
  input  logic [glcm_pkg::READ_W-1:0]           req_row,
  input  logic [glcm_pkg::READ_W-1:0]           req_col,
  output logic                                  res_vld,
  output logic [COUNT_BITS-1:0]                 res_count,
  output logic [glcm_pkg::READ_W-1:0]           res_row,
  output logic [glcm_pkg::READ_W-1:0]           res_col,
  output logic                                  clr_done
);

  localparam int unsigned DEPTH  = MAX_BINS * MAX_BINS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned RW     = glcm_pkg::READ_W;

  logic [COUNT_BITS-1:0] mem [DEPTH];

  logic                  clr_busy_r;
  logic [ADDR_W-1:0]     clr_addr_r;
  glcm_pkg::mem_ctl_t    ctl1_r;
  logic [ADDR_W-1:0]     addr1_r;
  logic [RW-1:0]         row1_r;
  logic [RW-1:0]         col1_r;
  logic [COUNT_BITS-1:0] rdata_r;
  logic                  fwd_hit_r;
  logic [COUNT_BITS-1:0] fwd_data_r;

  logic [COUNT_BITS-1:0] old;
  logic [COUNT_BITS-1:0] upd;
  logic                  wen_item;
  logic                  wen;
  logic [ADDR_W-1:0]     waddr;
  logic [COUNT_BITS-1:0] wdata;

  always_comb begin
    old      = fwd_hit_r ? fwd_data_r : rdata_r;
    if (ctl1_r.rd) begin
      upd = '0;
    end else begin
      upd = (old == '1) ? old : old + COUNT_BITS'(1);
    end
    wen_item = ctl1_r.vld && (!ctl1_r.rd || ctl1_r.hit);
    wen      = clr_busy_r || wen_item;
    waddr    = clr_busy_r ? clr_addr_r : addr1_r;
    wdata    = clr_busy_r ? '0 : upd;
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[req_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      ctl1_r     <= '0;
      fwd_hit_r  <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end else begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
        end
      end
      ctl1_r    <= req;
      // entry written this cycle is the one the next beat just read
      fwd_hit_r <= req.vld && wen_item && (addr1_r == req_addr);
    end
    fwd_data_r <= upd;
    addr1_r    <= req_addr;
    row1_r     <= req_row;
    col1_r     <= req_col;
  end

  assign res_vld   = ctl1_r.vld && ctl1_r.rd;
  assign res_count = ctl1_r.hit ? old : '0;
  assign res_row   = row1_r;
  assign res_col   = col1_r;
  assign clr_done  = !clr_busy_r;

endmodule
